### rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the text console writer.
// Used by the controller, the datapath and the top level; depends on nothing.
package tcw_pkg;

    localparam int LOC_W  = 11;
    localparam int DATA_W = 16;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 11;

    localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [DATA_W-1:0] ATTR_MASK    = 16'hFF00;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RMW,
        S_WRAP,
        S_SCROLL,
        S_EMIT,
        S_EMIT_RD
    } t_state;

    typedef enum logic [1:0] {
        CK_NUL,
        CK_NEWLINE,
        CK_BACKSPACE,
        CK_PRINT
    } t_char_kind;

    typedef enum logic [1:0] {
        RD_CURSOR,
        RD_CURSOR_BACK,
        RD_ADDR,
        RD_SCAN
    } t_rd_sel;

    typedef enum logic [1:0] {
        COL_HOLD,
        COL_INC,
        COL_DEC,
        COL_NEWLINE
    } t_col_op;

    typedef struct packed {
        logic    load;
        logic    clear_step;
        logic    mem_rd;
        t_rd_sel rd_sel;
        logic    byte_space;
        t_col_op col_op;
        logic    rmw_write;
        logic    wrap;
        logic    scroll_step;
        logic    emit;
        logic    emit_mem;
    } t_dp_cmd;

    typedef struct packed {
        logic       is_read;
        logic       addr_in_range;
        t_char_kind char_kind;
        logic       col_zero;
        logic       scan_last;
        logic       need_scroll;
    } t_dp_status;

endpackage

### rtl/text_console_writer_core.sv
`timescale 1ns / 1ps
// Text console writer: COLUMNS x ROWS screen of 16-bit cells with a cursor.
// Top level; depends on tcw_pkg, tcw_ctrl, tcw_dp and tcw_ram.
//
// Usage: drive i_opcode, i_char_code and i_cell_address with start high; the
// transaction is taken at the rising edge where start is high and busy low.
// A put (opcode 0) writes a character at the cursor, handling newline,
// backspace, column wrap and scrolling; a read (opcode 1) returns one cell.
// Each transaction produces exactly one result, presented for one cycle with
// o_done high, carrying the cursor location and the cell data (zero for puts
// and for reads beyond the screen). The receiver cannot stall the result.
// A read, or a put that causes no memory update, goes from EXEC straight to
// EMIT_RD or EMIT; a newline passes through WRAP on the way, and a printable
// character or a backspace through RMW and then WRAP. A put that scrolls also
// passes through SCROLL, which copies every cell, one at a time, since the copy
// goes through the single write port of the screen memory. busy falls in the
// cycle o_done rises, so the next transaction may start there.
// After reset the block clears the screen memory, one cell per cycle, with busy
// held high.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ADDR_W-1:0] i_cell_address,
    output logic              o_done,
    output logic [LOC_W-1:0]  o_cursor_location,
    output logic [DATA_W-1:0] o_cell_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_cmd    (dp_cmd),
        .i_status (dp_status)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_opcode          (i_opcode),
        .i_char_code       (i_char_code),
        .i_cell_address    (i_cell_address),
        .o_done            (o_done),
        .o_cursor_location (o_cursor_location),
        .o_cell_data       (o_cell_data)
    );

endmodule

### rtl/tcw_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; no package needed.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tcw_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the text console writer.
// Depends on tcw_pkg for the state, command and status types.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.is_read) begin
                    if (i_status.addr_in_range) begin
                        o_cmd.mem_rd = 1'b1;
                        o_cmd.rd_sel = RD_ADDR;
                        n_state      = S_EMIT_RD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    case (i_status.char_kind)
                        CK_NUL: begin
                            n_state = S_EMIT;
                        end
                        CK_NEWLINE: begin
                            o_cmd.col_op = COL_NEWLINE;
                            n_state      = S_WRAP;
                        end
                        CK_BACKSPACE: begin
                            if (i_status.col_zero) begin
                                n_state = S_EMIT;
                            end else begin
                                o_cmd.mem_rd     = 1'b1;
                                o_cmd.rd_sel     = RD_CURSOR_BACK;
                                o_cmd.byte_space = 1'b1;
                                o_cmd.col_op     = COL_DEC;
                                n_state          = S_RMW;
                            end
                        end
                        default: begin
                            o_cmd.mem_rd = 1'b1;
                            o_cmd.rd_sel = RD_CURSOR;
                            o_cmd.col_op = COL_INC;
                            n_state      = S_RMW;
                        end
                    endcase
                end
            end
            S_RMW: begin
                o_cmd.rmw_write = 1'b1;
                n_state         = S_WRAP;
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = i_status.need_scroll ? S_SCROLL : S_EMIT;
            end
            S_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
                o_cmd.mem_rd      = 1'b1;
                o_cmd.rd_sel      = RD_SCAN;
                if (i_status.scan_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            S_EMIT_RD: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_mem = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/tcw_dp.sv
`timescale 1ns / 1ps
// Datapath of the text console writer: cursor, screen memory, scan counter
// and result registers. Depends on tcw_pkg and tcw_ram.
module tcw_dp
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic              i_opcode,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ADDR_W-1:0] i_cell_address,
    output logic              o_done,
    output logic [LOC_W-1:0]  o_cursor_location,
    output logic [DATA_W-1:0] o_cell_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS + 1);
    localparam int ROW_W      = $clog2(ROWS + 1);
    localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;

    logic              r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [ADDR_W-1:0] r_addr;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CELL_W-1:0] r_scan;
    logic              r_pend_valid;
    logic [CELL_W-1:0] r_pend_addr;
    logic              r_pend_blank;
    logic [CELL_W-1:0] r_rmw_addr;
    logic [CHAR_W-1:0] r_rmw_byte;
    logic              r_out_valid;
    logic [LOC_W-1:0]  r_out_loc;
    logic [DATA_W-1:0] r_out_data;

    logic [CELL_W-1:0] cur_idx;
    logic [CELL_W-1:0] back_idx;
    logic [CELL_W-1:0] scan_src;
    logic [CELL_W-1:0] rd_addr;
    logic              mem_we;
    logic [CELL_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;
    logic              col_wrap;
    logic [ROW_W-1:0]  row_wrapped;
    logic              need_scroll;
    logic              scan_last;
    logic [LOC_W-1:0]  cur_loc;

    assign cur_idx  = CELL_W'(32'(r_row) * 32'(COLUMNS) + 32'(r_col));
    assign back_idx = CELL_W'(32'(r_row) * 32'(COLUMNS) + 32'(r_col) - 32'd1);
    assign cur_loc  = LOC_W'(32'(r_row) * 32'(COLUMNS) + 32'(r_col));

    // During a scroll, rows above the last one copy from the row below; the
    // last row reads itself back so that only its character bytes get blanked.
    assign scan_src = (32'(r_scan) < 32'(LAST_BASE)) ?
                      CELL_W'(32'(r_scan) + 32'(COLUMNS)) : r_scan;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_CURSOR:      rd_addr = cur_idx;
            RD_CURSOR_BACK: rd_addr = back_idx;
            RD_ADDR:        rd_addr = CELL_W'(r_addr);
            default:        rd_addr = scan_src;
        endcase
    end

    // Write sources never overlap in time; the pending scroll write comes in the
    // cycle after its read.
    always_comb begin
        mem_we    = 1'b1;
        mem_waddr = r_pend_addr;
        mem_wdata = r_pend_blank ? ((mem_rdata & ATTR_MASK) | DATA_W'(BLANK_CHAR))
                                 : mem_rdata;
        if (i_cmd.clear_step) begin
            mem_waddr = r_scan;
            mem_wdata = '0;
        end else if (i_cmd.rmw_write) begin
            mem_waddr = r_rmw_addr;
            mem_wdata = (mem_rdata & ATTR_MASK) | DATA_W'(r_rmw_byte);
        end else if (!r_pend_valid) begin
            mem_we = 1'b0;
        end
    end

    tcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.mem_rd),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    assign col_wrap    = (r_col == COL_W'(COLUMNS));
    assign row_wrapped = r_row + ROW_W'(col_wrap);
    assign need_scroll = (row_wrapped == ROW_W'(ROWS));
    assign scan_last   = (r_scan == CELL_W'(CELL_COUNT - 1));

    always_comb begin
        o_status               = '0;
        o_status.is_read       = (r_op == OP_READ);
        o_status.addr_in_range = (32'(r_addr) < 32'(CELL_COUNT));
        o_status.col_zero      = (r_col == '0);
        o_status.scan_last     = scan_last;
        o_status.need_scroll   = need_scroll;
        if (r_ch == CH_NUL) begin
            o_status.char_kind = CK_NUL;
        end else if (r_ch == CH_NEWLINE) begin
            o_status.char_kind = CK_NEWLINE;
        end else if (r_ch == CH_BACKSPACE) begin
            o_status.char_kind = CK_BACKSPACE;
        end else begin
            o_status.char_kind = CK_PRINT;
        end
    end

    // Control state: cursor, scan counter and strobes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_scan       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pend_valid <= i_cmd.scroll_step;
            r_out_valid  <= i_cmd.emit;
            case (i_cmd.col_op)
                COL_INC: r_col <= r_col + COL_W'(1);
                COL_DEC: r_col <= r_col - COL_W'(1);
                COL_NEWLINE: begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end
                default: ;
            endcase
            if (i_cmd.clear_step || i_cmd.scroll_step) begin
                r_scan <= scan_last ? '0 : r_scan + CELL_W'(1);
            end
            if (i_cmd.wrap) begin
                if (col_wrap) begin
                    r_col <= '0;
                end
                if (need_scroll) begin
                    r_row  <= ROW_W'(ROWS - 1);
                    r_scan <= '0;
                end else begin
                    r_row <= row_wrapped;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_ch   <= i_char_code;
            r_addr <= i_cell_address;
        end
        if (i_cmd.mem_rd) begin
            r_rmw_addr <= rd_addr;
            r_rmw_byte <= i_cmd.byte_space ? BLANK_CHAR : r_ch;
        end
        if (i_cmd.scroll_step) begin
            r_pend_addr  <= r_scan;
            r_pend_blank <= (32'(r_scan) >= 32'(LAST_BASE));
        end
        if (i_cmd.emit) begin
            r_out_loc  <= cur_loc;
            r_out_data <= i_cmd.emit_mem ? mem_rdata : '0;
        end
    end

    assign o_done            = r_out_valid;
    assign o_cursor_location = r_out_loc;
    assign o_cell_data       = r_out_data;

endmodule

### sim/tb_text_console_writer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer_core: puts and reads are
// checked against a behavioral model of the screen buffer and cursor.
// Depends on tcw_pkg and the RTL of text_console_writer_core.
module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int CELLS          = COLUMNS * ROWS;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 16;

    typedef struct packed {
        logic [LOC_W-1:0]  loc;
        logic [DATA_W-1:0] data;
    } t_console_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_opcode;
    logic [CHAR_W-1:0] i_char_code;
    logic [ADDR_W-1:0] i_cell_address;
    logic              o_done;
    logic [LOC_W-1:0]  o_cursor_location;
    logic [DATA_W-1:0] o_cell_data;

    // Behavioral copy of the screen and cursor.
    logic [DATA_W-1:0] screen_model [CELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;

    t_console_result   pending_results [$];
    t_console_result   oldest;
    int unsigned       idle_pct;
    int unsigned       put_count;
    int unsigned       read_count;
    int unsigned       scroll_count;
    int unsigned       results_checked;
    int unsigned       mismatch_count;
    int unsigned       stall_cycles;

    text_console_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_char_code      (i_char_code),
        .i_cell_address   (i_cell_address),
        .o_done           (o_done),
        .o_cursor_location(o_cursor_location),
        .o_cell_data      (o_cell_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void set_low_byte(int unsigned idx, logic [CHAR_W-1:0] ch);
        screen_model[idx] = (screen_model[idx] & ATTR_MASK) | {8'h00, ch};
    endfunction

    // Applies one transaction to the screen model and returns what the block
    // should report for it.
    function automatic t_console_result console_step(logic op, logic [CHAR_W-1:0] ch,
                                                     logic [ADDR_W-1:0] addr);
        t_console_result r;
        r.data = '0;
        if (op == OP_PUT) begin
            if (ch == CH_NEWLINE) begin
                cur_col = 0;
                cur_row++;
            end else if (ch == CH_BACKSPACE) begin
                if (cur_col > 0) begin
                    cur_col--;
                    set_low_byte(cur_row * COLUMNS + cur_col, BLANK_CHAR);
                end
            end else if (ch != CH_NUL) begin
                set_low_byte(cur_row * COLUMNS + cur_col, ch);
                cur_col++;
            end
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= ROWS) begin
                for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                    screen_model[i] = screen_model[i + COLUMNS];
                for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                    set_low_byte(i, BLANK_CHAR);
                cur_row = ROWS - 1;
                scroll_count++;
            end
        end else if (addr < CELLS) begin
            r.data = screen_model[addr];
        end
        r.loc = LOC_W'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    // Any byte that is stored as a character: not NUL, newline or backspace.
    function automatic logic [CHAR_W-1:0] random_glyph();
        logic [CHAR_W-1:0] ch;
        do
            ch = CHAR_W'($urandom_range(1, 255));
        while (ch == CH_NEWLINE || ch == CH_BACKSPACE);
        return ch;
    endfunction

    // Called at a falling edge; returns at the falling edge after the
    // transaction is taken, with start still high for a following item.
    task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                             input logic [ADDR_W-1:0] addr);
        if ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        start          = 1'b1;
        i_opcode       = op;
        i_char_code    = ch;
        i_cell_address = addr;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_results.push_back(console_step(op, ch, addr));
        if (op == OP_PUT) put_count++;
        else read_count++;
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
        int unsigned       pick;
        int unsigned       row;
        pick = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom_range(0, 255));
        addr = ADDR_W'($urandom_range(0, 2047));
        if (pick < 45) begin
            if ($urandom_range(0, 2) != 0) begin
                row  = (cur_row == 0) ? 0 : cur_row - $urandom_range(0, 1);
                addr = ADDR_W'(row * COLUMNS + $urandom_range(0, COLUMNS - 1));
            end
            send_item(OP_READ, ch, addr);
        end else begin
            if (pick < 52)      ch = CH_BACKSPACE;
            else if (pick < 55) ch = CH_NEWLINE;
            else if (pick < 58) ch = CH_NUL;
            else if (pick < 75) ch = CHAR_W'($urandom_range(0, 255));
            else                ch = random_glyph();
            send_item(OP_PUT, ch, addr);
        end
    endtask

    task automatic test_directed_cases();
        idle_pct = 25;
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_PUT, CH_NUL, 11'h7FF);
        send_item(OP_PUT, CH_BACKSPACE, 11'd0);
        send_item(OP_PUT, 8'h01, 11'd0);
        send_item(OP_PUT, 8'hFF, 11'd0);
        send_item(OP_PUT, 8'h80, 11'd0);
        send_item(OP_PUT, 8'h7F, 11'd0);
        send_item(OP_PUT, CH_BACKSPACE, 11'd0);
        for (int a = 0; a < 4; a++)
            send_item(OP_READ, 8'hFF, ADDR_W'(a));
        send_item(OP_PUT, CH_NEWLINE, 11'd0);
        send_item(OP_PUT, 8'h41, 11'd0);
        send_item(OP_READ, 8'h00, 11'd80);
        send_item(OP_READ, 8'h00, 11'd1999);
        send_item(OP_READ, 8'h00, 11'd2000);
        send_item(OP_READ, 8'h00, 11'd2047);
        send_item(OP_READ, 8'h00, 11'd1024);
        send_item(OP_PUT, CH_NUL, 11'd0);
    endtask

    // Lines of random text ended by newlines, some long enough to wrap, with
    // the odd correction; the screen fills and then scrolls line by line.
    task automatic test_text_lines();
        int unsigned len;
        int unsigned sel;
        idle_pct = 30;
        for (int line = 0; line < 36; line++) begin
            sel = $urandom_range(0, 9);
            if (sel < 7)      len = $urandom_range(0, 20);
            else if (sel < 9) len = $urandom_range(21, 79);
            else              len = $urandom_range(80, 100);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(OP_PUT, CH_BACKSPACE, ADDR_W'($urandom_range(0, 2047)));
                else
                    send_item(OP_PUT, random_glyph(), ADDR_W'($urandom_range(0, 2047)));
            end
            send_item(OP_PUT, CH_NEWLINE, ADDR_W'($urandom_range(0, 2047)));
            repeat (2)
                send_item(OP_READ, CHAR_W'($urandom_range(0, 255)),
                          ADDR_W'($urandom_range(0, CELLS - 1)));
        end
    endtask

    // Backspace runs that go past column zero, then a read-back of the first four cells of the row.
    task automatic test_backspace_runs();
        int unsigned len;
        int unsigned row_base;
        idle_pct = 20;
        for (int run = 0; run < 5; run++) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
                send_item(OP_PUT, random_glyph(), ADDR_W'($urandom_range(0, 2047)));
            for (int k = 0; k < len + 3; k++)
                send_item(OP_PUT, CH_BACKSPACE, ADDR_W'($urandom_range(0, 2047)));
            row_base = cur_row * COLUMNS;
            for (int k = 0; k < 4; k++)
                send_item(OP_READ, 8'h00, ADDR_W'(row_base + k));
        end
    endtask

    task automatic test_random_mix();
        for (int blk = 0; blk < 8; blk++) begin
            idle_pct = ($urandom_range(0, 1) != 0) ? 35 : 0;
            repeat (50) send_random_item();
        end
    endtask

    // Full-rate traffic, including a wrap and a scroll, with no idle cycles.
    task automatic test_back_to_back();
        idle_pct = 0;
        repeat (COLUMNS + 5)
            send_item(OP_PUT, random_glyph(), ADDR_W'($urandom_range(0, 2047)));
        repeat (150) send_random_item();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_opcode        = OP_PUT;
        i_char_code     = '0;
        i_cell_address  = '0;
        idle_pct        = 0;
        put_count       = 0;
        read_count      = 0;
        scroll_count    = 0;
        results_checked = 0;
        mismatch_count  = 0;
        cur_col         = 0;
        cur_row         = 0;
        for (int i = 0; i < CELLS; i++) screen_model[i] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_text_lines();
        test_backspace_runs();
        test_random_mix();
        test_back_to_back();
        start = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d results from %0d puts and %0d reads.",
                 results_checked, put_count, read_count);
        $display("The screen scrolled %0d times, with wraps and backspaces at column zero.",
                 scroll_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Each result is taken at the rising edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: cursor_location %0d cell_data 0x%04h",
                       o_cursor_location, o_cell_data);
                mismatch_count++;
            end else begin
                oldest = pending_results.pop_front();
                results_checked++;
                if (o_cursor_location !== oldest.loc) begin
                    $error("cursor_location: expected %0d, got %0d",
                           oldest.loc, o_cursor_location);
                    mismatch_count++;
                end
                if (o_cell_data !== oldest.data) begin
                    $error("cell_data: expected 0x%04h, got 0x%04h",
                           oldest.data, o_cell_data);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
